// ===== design/cesl_pkg.sv =====
// shared types, sizes and codes for the clip edge smoothing limiter
package cesl_pkg;

    // sample and fixed-point sizes
    localparam int SAMPLE_BITS   = 24;
    localparam int MAX_DELAY_DEF = 16;
    localparam int Q_W           = 24;
    localparam int Q_FRAC        = 20;
    localparam int COEF_FRAC     = 24;

    // configuration register sizes
    localparam int GAIN_IN_W  = 24;
    localparam int GAIN_OUT_W = 17;
    localparam int DELAY_W    = 5;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BYPASS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_GAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELAY_LEN   = 2'd3;

    // datapath step codes, in the order the controller runs them
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] ST_IN  = 3'd0;
    localparam logic [STEP_W-1:0] ST_POS = 3'd1;
    localparam logic [STEP_W-1:0] ST_CLP = 3'd2;
    localparam logic [STEP_W-1:0] ST_NEG = 3'd3;
    localparam logic [STEP_W-1:0] ST_CLN = 3'd4;
    localparam logic [STEP_W-1:0] ST_OUT = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_data_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_data_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              pass;
        logic              mul;
        logic              rnd;
        logic              finish;
        logic [STEP_W-1:0] step;
    } cmd_t;

    // top level to controller
    typedef struct packed {
        logic in_valid;
        logic bypass;
        logic out_free;
    } ctrl_status_t;

endpackage

// ===== design/cesl_ctrl.sv =====
// sequencing controller: steps both lanes through multiply and round phases
module cesl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cesl_pkg::ctrl_status_t status,
    output cesl_pkg::cmd_t        cmd,
    output logic                  ready
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic                        state_reg;
    logic                        state_next;
    logic [cesl_pkg::STEP_W-1:0] step_reg;
    logic [cesl_pkg::STEP_W-1:0] step_next;
    logic                        phase_reg;
    logic                        phase_next;
    logic                        take;
    logic                        last_step;

    assign ready     = (state_reg == S_IDLE) && (!status.bypass || status.out_free);
    assign take      = status.in_valid && ready;
    assign last_step = (step_reg == cesl_pkg::ST_OUT);

    always_comb
    begin
        cmd.load   = take && !status.bypass;
        cmd.pass   = take && status.bypass;
        cmd.mul    = (state_reg == S_RUN) && !phase_reg;
        cmd.rnd    = (state_reg == S_RUN) && phase_reg && (!last_step || status.out_free);
        cmd.finish = (state_reg == S_RUN) && phase_reg && last_step && status.out_free;
        cmd.step   = step_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_RUN;
                    step_next  = cesl_pkg::ST_IN;
                    phase_next = 1'b0;
                end
            end
            S_RUN:
            begin
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else if (last_step)
                begin
                    // hold the round phase until the output slot frees
                    if (status.out_free)
                    begin
                        state_next = S_IDLE;
                        phase_next = 1'b0;
                    end
                end
                else
                begin
                    step_next  = step_reg + 3'd1;
                    phase_next = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= cesl_pkg::ST_IN;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== design/cesl_lane.sv =====
// one channel datapath: shared multiplier, clip-edge state and delay line
module cesl_lane #(
    parameter int MAX_DELAY = cesl_pkg::MAX_DELAY_DEF,
    parameter int LEN_W     = $clog2(MAX_DELAY + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cesl_pkg::cmd_t                        cmd,
    input  logic signed [cesl_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [cesl_pkg::GAIN_IN_W-1:0]        input_gain,
    input  logic [cesl_pkg::GAIN_OUT_W-1:0]       output_gain,
    input  logic [LEN_W-1:0]                      len,
    output logic signed [cesl_pkg::SAMPLE_BITS-1:0] result
);

    localparam int SB     = cesl_pkg::SAMPLE_BITS;
    localparam int Q_W    = cesl_pkg::Q_W;
    localparam int MUL_W  = ((SB > Q_W) ? SB : Q_W) + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int OFF_W  = 26;
    localparam int SH_IN  = SB - 5;
    localparam int SH_OUT = 37 - SB;

    localparam logic signed [OFF_W-1:0] OFF_A   = 26'sd11841708;
    localparam logic signed [OFF_W-1:0] OFF_B   = 26'sd4180407;
    localparam logic signed [MUL_W-1:0] COEF_A  = MUL_W'(4377424);
    localparam logic signed [MUL_W-1:0] COEF_B  = MUL_W'(12399790);
    localparam logic signed [Q_W-1:0]   CLIP_HI = 24'sd1001382;
    localparam logic signed [Q_W-1:0]   CLIP_LO = -CLIP_HI;

    localparam logic signed [Q_W-1:0]   Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0]   Q_MIN  = ~Q_MAX;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(Q_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(Q_MIN);
    localparam logic signed [ACC_W-1:0] IP_RND = ACC_W'(1) <<< (cesl_pkg::COEF_FRAC - 1);

    localparam logic signed [PROD_W-1:0] IN_LIM   = PROD_W'(1) <<< (SB + 17);
    localparam logic signed [PROD_W-1:0] IN_LIM_N = -IN_LIM;
    localparam logic signed [PROD_W-1:0] IN_RND   = PROD_W'(1) <<< (SH_IN - 1);

    localparam logic signed [SB-1:0]     S_MAX   = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0]     S_MIN   = ~S_MAX;
    localparam logic signed [PROD_W-1:0] OUT_HI  = PROD_W'(S_MAX);
    localparam logic signed [PROD_W-1:0] OUT_LO  = PROD_W'(S_MIN);
    localparam logic signed [PROD_W-1:0] OUT_RND = PROD_W'(1) <<< (SH_OUT - 1);

    // off * 2^20 + product, rounded to q3.20 and saturated
    function automatic logic signed [Q_W-1:0] interp(
        input logic signed [OFF_W-1:0]  off,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] q;
        acc = (ACC_W'(off) <<< cesl_pkg::Q_FRAC) + ACC_W'(p) + IP_RND;
        q   = acc >>> cesl_pkg::COEF_FRAC;
        if (q > SAT_HI)
            interp = Q_MAX;
        else if (q < SAT_LO)
            interp = Q_MIN;
        else
            interp = q[Q_W-1:0];
    endfunction

    // clamp to +-4.0 then round to q3.20
    function automatic logic signed [Q_W-1:0] scale_in(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] pc;
        logic signed [PROD_W-1:0] q;
        if (p > IN_LIM)
            pc = IN_LIM;
        else if (p < IN_LIM_N)
            pc = IN_LIM_N;
        else
            pc = p;
        q = (pc + IN_RND) >>> SH_IN;
        scale_in = q[Q_W-1:0];
    endfunction

    // round q3.20 times q1.16 to the output format and saturate
    function automatic logic signed [SB-1:0] scale_out(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] q;
        q = (p + OUT_RND) >>> SH_OUT;
        if (q > OUT_HI)
            scale_out = S_MAX;
        else if (q < OUT_LO)
            scale_out = S_MIN;
        else
            scale_out = q[SB-1:0];
    endfunction

    logic signed [SB-1:0]     raw_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [Q_W-1:0]    x_reg;
    logic signed [Q_W-1:0]    x_next;
    logic signed [Q_W-1:0]    held_reg;
    logic signed [Q_W-1:0]    held_next;
    logic                     pos_reg;
    logic                     pos_next;
    logic                     neg_reg;
    logic                     neg_next;
    logic signed [Q_W-1:0]    line_reg  [MAX_DELAY];
    logic signed [Q_W-1:0]    line_next [MAX_DELAY];

    logic signed [MUL_W-1:0]  a_op;
    logic signed [MUL_W-1:0]  b_op;
    logic signed [OFF_W-1:0]  off_sel;
    logic signed [Q_W-1:0]    ip;
    logic                     x_lt;
    logic                     x_gt;

    assign x_lt   = x_reg < held_reg;
    assign x_gt   = x_reg > held_reg;
    assign ip     = interp(off_sel, prod_reg);
    assign result = scale_out(prod_reg);

    // multiplier operands and interpolation offset per step
    always_comb
    begin
        a_op    = '0;
        b_op    = '0;
        off_sel = '0;
        unique case (cmd.step)
            cesl_pkg::ST_IN:
            begin
                a_op = MUL_W'(raw_reg);
                b_op = MUL_W'(input_gain);
            end
            cesl_pkg::ST_POS:
            begin
                a_op    = x_lt ? MUL_W'(x_reg) : MUL_W'(held_reg);
                b_op    = x_lt ? COEF_A : COEF_B;
                off_sel = x_lt ? OFF_A : OFF_B;
            end
            cesl_pkg::ST_CLP:
            begin
                a_op    = MUL_W'(held_reg);
                b_op    = COEF_A;
                off_sel = OFF_A;
            end
            cesl_pkg::ST_NEG:
            begin
                a_op    = x_gt ? MUL_W'(x_reg) : MUL_W'(held_reg);
                b_op    = x_gt ? COEF_A : COEF_B;
                off_sel = x_gt ? -OFF_A : -OFF_B;
            end
            cesl_pkg::ST_CLN:
            begin
                a_op    = MUL_W'(held_reg);
                b_op    = COEF_A;
                off_sel = -OFF_A;
            end
            cesl_pkg::ST_OUT:
            begin
                a_op = MUL_W'(held_reg);
                b_op = MUL_W'(output_gain);
            end
            default:
            begin
                a_op = '0;
            end
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        held_next = held_reg;
        pos_next  = pos_reg;
        neg_next  = neg_reg;
        line_next = line_reg;
        if (cmd.rnd)
        begin
            unique case (cmd.step)
                cesl_pkg::ST_IN:
                begin
                    x_next = scale_in(prod_reg);
                end
                cesl_pkg::ST_POS:
                begin
                    // leaving positive clip: soften the held sample
                    if (pos_reg)
                    begin
                        held_next = ip;
                        pos_next  = 1'b0;
                    end
                end
                cesl_pkg::ST_CLP:
                begin
                    if (x_reg > CLIP_HI)
                    begin
                        pos_next = 1'b1;
                        x_next   = ip;
                    end
                end
                cesl_pkg::ST_NEG:
                begin
                    if (neg_reg)
                    begin
                        held_next = ip;
                        neg_next  = 1'b0;
                    end
                end
                cesl_pkg::ST_CLN:
                begin
                    if (x_reg < CLIP_LO)
                    begin
                        neg_next = 1'b1;
                        x_next   = ip;
                    end
                end
                default:
                begin
                    x_next = x_reg;
                end
            endcase
        end
        if (cmd.finish)
        begin
            // shift the active part of the line toward entry 0
            for (int k = 0; k < MAX_DELAY - 1; k++)
            begin
                if (LEN_W'(k + 1) < len)
                    line_next[k] = line_reg[k + 1];
            end
            for (int k = 0; k < MAX_DELAY; k++)
            begin
                if (LEN_W'(k + 1) == len)
                    line_next[k] = x_reg;
            end
            held_next = line_next[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            raw_reg <= sample;
        if (cmd.mul)
            prod_reg <= a_op * b_op;
        x_reg <= x_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            pos_reg  <= 1'b0;
            neg_reg  <= 1'b0;
            for (int k = 0; k < MAX_DELAY; k++)
                line_reg[k] <= '0;
        end
        else
        begin
            held_reg <= held_next;
            pos_reg  <= pos_next;
            neg_reg  <= neg_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== design/clip_edge_smoothing_limiter.sv =====
// top level of the stereo clip edge smoothing limiter
// stereo clip-edge smoother with a per-channel delay line of 1 to MAX_DELAY
// samples. both channels run in parallel in two identical lanes. a normal
// transaction has its result standing in the output register after six
// dependent multiply and round steps, each a multiply phase and a round phase
// (input gain, two softening steps, two clip steps, output gain), through each
// lane's one multiplier. the next transaction can be taken in the cycle after
// the result is written, so no new transaction is taken before the last is
// through; a stalled output holds the last step until the output slot frees.
// in bypass a transaction is written into the output register as it is taken
// and the lane state is left alone. outside bypass the output register frees
// the input side, so a new transaction is taken while a result still waits.
// configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce;
// a delay length of 0 acts as 1 and one above MAX_DELAY acts as MAX_DELAY
module clip_edge_smoothing_limiter #(
    parameter int MAX_DELAY = cesl_pkg::MAX_DELAY_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  cesl_pkg::in_data_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output cesl_pkg::out_data_t               out_data,
    input  logic                              cfg_write,
    input  logic [cesl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cesl_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LEN_W = $clog2(MAX_DELAY + 1);
    localparam int CMP_W = (LEN_W > cesl_pkg::DELAY_W) ? LEN_W : cesl_pkg::DELAY_W;

    // configuration registers
    logic                              bypass_reg;
    logic [cesl_pkg::GAIN_IN_W-1:0]    input_gain_reg;
    logic [cesl_pkg::GAIN_OUT_W-1:0]   output_gain_reg;
    logic [cesl_pkg::DELAY_W-1:0]      delay_length_reg;

    // output register
    logic                              out_valid_reg;
    logic                              out_valid_next;
    cesl_pkg::out_data_t               out_reg;

    cesl_pkg::ctrl_status_t            status;
    cesl_pkg::cmd_t                    cmd;
    logic                              ready;
    logic                              out_free;
    logic [CMP_W-1:0]                  dl_wide;
    logic [LEN_W-1:0]                  len_eff;
    logic signed [cesl_pkg::SAMPLE_BITS-1:0] left_res;
    logic signed [cesl_pkg::SAMPLE_BITS-1:0] right_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg       <= 1'b0;
            input_gain_reg   <= 24'd65536;
            output_gain_reg  <= 17'd65536;
            delay_length_reg <= 5'd1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cesl_pkg::REG_BYPASS:      bypass_reg       <= cfg_data[0];
                cesl_pkg::REG_INPUT_GAIN:  input_gain_reg   <= cfg_data[cesl_pkg::GAIN_IN_W-1:0];
                cesl_pkg::REG_OUTPUT_GAIN: output_gain_reg  <= cfg_data[cesl_pkg::GAIN_OUT_W-1:0];
                cesl_pkg::REG_DELAY_LEN:   delay_length_reg <= cfg_data[cesl_pkg::DELAY_W-1:0];
                default:                   bypass_reg       <= bypass_reg;
            endcase
        end
    end

    // clamp the delay length into 1 .. MAX_DELAY
    assign dl_wide = CMP_W'(delay_length_reg);

    always_comb
    begin
        priority if (dl_wide == '0)
            len_eff = LEN_W'(1);
        else if (dl_wide > CMP_W'(MAX_DELAY))
            len_eff = LEN_W'(MAX_DELAY);
        else
            len_eff = LEN_W'(dl_wide);
    end

    // output slot is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.in_valid = in_valid;
        status.bypass   = bypass_reg;
        status.out_free = out_free;
    end

    cesl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd),
        .ready  (ready)
    );

    cesl_lane #(
        .MAX_DELAY (MAX_DELAY),
        .LEN_W     (LEN_W)
    ) u_lane_left (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (in_data.left_sample),
        .input_gain  (input_gain_reg),
        .output_gain (output_gain_reg),
        .len         (len_eff),
        .result      (left_res)
    );

    cesl_lane #(
        .MAX_DELAY (MAX_DELAY),
        .LEN_W     (LEN_W)
    ) u_lane_right (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      (in_data.right_sample),
        .input_gain  (input_gain_reg),
        .output_gain (output_gain_reg),
        .len         (len_eff),
        .result      (right_res)
    );

    assign in_stall = !ready;

    always_comb
    begin
        priority if (cmd.pass || cmd.finish)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // bypass copies the input transaction, otherwise the lane results
    always_ff @(posedge clk)
    begin
        if (cmd.pass)
        begin
            out_reg.left_out  <= in_data.left_sample;
            out_reg.right_out <= in_data.right_sample;
        end
        else if (cmd.finish)
        begin
            out_reg.left_out  <= left_res;
            out_reg.right_out <= right_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // no input transaction while the lanes are busy
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul || cmd.rnd) |-> in_stall)
        else $error("input taken while lanes busy");

    // a result is only written into a free output slot
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish || cmd.pass) |-> !(out_valid && out_stall))
        else $error("result overwrote a pending output");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result not presented");

    // bypass delivers the input transaction unchanged
    a_bypass_copy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass |=> (out_valid && (out_data == $past(in_data))))
        else $error("bypass output differs from input");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the clip edge smoothing limiter with its own bit-true predictor
`timescale 1ns / 1ps

module testbench;

    // fixed-point constants of the clip-edge interpolation, Q1.24 offsets and Q0.24 slopes
    localparam longint OFF_A    = 11841708;
    localparam longint SLOPE_A  = 4377424;
    localparam longint OFF_B    = 4180407;
    localparam longint SLOPE_B  = 12399790;
    localparam longint CLIP_THR = 1001382;
    localparam longint Q20_HI   = 8388607;
    localparam longint Q20_LO   = -8388608;
    // input product limit: 4.0 at 39 fractional bits (Q1.23 sample times Q8.16 gain)
    localparam longint IN_LIM   = 64'sd2199023255552;
    localparam int     MAX_LEN  = cesl_pkg::MAX_DELAY_DEF;
    localparam int     SETTLE   = 20;
    localparam int     LIMIT    = 500000;

    logic                fclk_unused_guard;
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    cesl_pkg::in_data_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    cesl_pkg::out_data_t out_data;
    logic                                cfg_write = 1'b0;
    logic [cesl_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [cesl_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

    // mirror of the configuration registers as the block should hold them
    logic                                cfg_bypass = 1'b0;
    logic [cesl_pkg::GAIN_IN_W-1:0]      cfg_in_gain = 24'd65536;
    logic [cesl_pkg::GAIN_OUT_W-1:0]     cfg_out_gain = 17'd65536;
    logic [cesl_pkg::DELAY_W-1:0]        cfg_delay = 5'd1;

    // predicted lane state, index 0 is left and 1 is right
    logic signed [cesl_pkg::Q_W-1:0] held_q [0:1];
    logic                            pos_clip [0:1];
    logic                            neg_clip [0:1];
    logic signed [cesl_pkg::Q_W-1:0] delay_q [0:1][0:MAX_LEN-1];

    // smoothed stereo pairs still owed by the block, oldest first
    cesl_pkg::out_data_t smoothed_q [$];

    int err_count = 0;
    int cycle_count = 0;
    int send_idle_pct = 20;
    int recv_idle_pct = 46;
    // long receiver hold-off, requested by bumping the sequence number
    int hold_len = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic signed [cesl_pkg::SAMPLE_BITS-1:0] last_left = '0;
    logic signed [cesl_pkg::SAMPLE_BITS-1:0] last_right = '0;

    clip_edge_smoothing_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // off + x*c at 44 fractional bits, rounded half up to Q3.20, saturated
    function automatic longint blend_q20(longint off, longint x, longint c);
        longint v;
        longint r;
        v = off * 1048576 + x * c;
        r = (v + 8388608) >>> 24;
        if (r > Q20_HI)
            r = Q20_HI;
        if (r < Q20_LO)
            r = Q20_LO;
        return r;
    endfunction

    // input sample times input gain, clamped to +-4.0, rounded to Q3.20
    function automatic longint in_gain_q20(logic signed [cesl_pkg::SAMPLE_BITS-1:0] s);
        longint sv;
        longint g;
        longint p;
        sv = longint'(s);
        g = longint'(cfg_in_gain);
        p = sv * g;
        if (p > IN_LIM)
            p = IN_LIM;
        if (p < -IN_LIM)
            p = -IN_LIM;
        return (p + 262144) >>> 19;
    endfunction

    // held Q3.20 sample times output gain, rounded to Q1.23, saturated
    function automatic longint out_gain_q23(longint h);
        longint g;
        longint r;
        g = longint'(cfg_out_gain);
        r = (h * g + 4096) >>> 13;
        if (r > Q20_HI)
            r = Q20_HI;
        if (r < Q20_LO)
            r = Q20_LO;
        return r;
    endfunction

    // one channel: clip-edge handling, output from the held sample, then the delay line
    function automatic logic signed [cesl_pkg::SAMPLE_BITS-1:0] lane_step(int ch,
            logic signed [cesl_pkg::SAMPLE_BITS-1:0] raw, int len);
        longint x;
        longint h;
        longint y;
        int k;
        x = in_gain_q20(raw);
        h = longint'(held_q[ch]);
        // leaving a positive clip softens the held sample toward the edge
        if (pos_clip[ch])
        begin
            if (x < h)
                h = blend_q20(OFF_A, x, SLOPE_A);
            else
                h = blend_q20(OFF_B, h, SLOPE_B);
            pos_clip[ch] = 1'b0;
        end
        if (x > CLIP_THR)
        begin
            pos_clip[ch] = 1'b1;
            x = blend_q20(OFF_A, h, SLOPE_A);
        end
        if (neg_clip[ch])
        begin
            if (x > h)
                h = blend_q20(-OFF_A, x, SLOPE_A);
            else
                h = blend_q20(-OFF_B, h, SLOPE_B);
            neg_clip[ch] = 1'b0;
        end
        if (x < -CLIP_THR)
        begin
            neg_clip[ch] = 1'b1;
            x = blend_q20(-OFF_A, h, SLOPE_A);
        end
        y = out_gain_q23(h);
        for (k = 0; k + 1 < len; k++)
            delay_q[ch][k] = delay_q[ch][k + 1];
        delay_q[ch][len - 1] = x[cesl_pkg::Q_W-1:0];
        held_q[ch] = delay_q[ch][0];
        return y[cesl_pkg::SAMPLE_BITS-1:0];
    endfunction

    function automatic cesl_pkg::out_data_t smooth_pair(cesl_pkg::in_data_t d);
        cesl_pkg::out_data_t r;
        int len;
        if (cfg_bypass)
        begin
            // straight through, lane state untouched
            r.left_out = d.left_sample;
            r.right_out = d.right_sample;
        end
        else
        begin
            len = int'(cfg_delay);
            if (len < 1)
                len = 1;
            if (len > MAX_LEN)
                len = MAX_LEN;
            r.left_out = lane_step(0, d.left_sample, len);
            r.right_out = lane_step(1, d.right_sample, len);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // drivers, all called right after a falling edge
    // ------------------------------------------------------------------

    // register write, mirrored into the predictor with the register's width
    task automatic apply_reg(logic [cesl_pkg::CFG_IDX_W-1:0] idx,
            logic [cesl_pkg::CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            cesl_pkg::REG_BYPASS:      cfg_bypass = val[0];
            cesl_pkg::REG_INPUT_GAIN:  cfg_in_gain = val[cesl_pkg::GAIN_IN_W-1:0];
            cesl_pkg::REG_OUTPUT_GAIN: cfg_out_gain = val[cesl_pkg::GAIN_OUT_W-1:0];
            cesl_pkg::REG_DELAY_LEN:   cfg_delay = val[cesl_pkg::DELAY_W-1:0];
            default:                   ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // offer one stereo transaction and hold it until the block takes it
    task automatic send_pair(cesl_pkg::in_data_t d);
        // random gap before the transaction; valid is never lowered and raised in one step
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        do
            @(posedge clk);
        while (in_stall);
        // accepted at this edge, so the prediction runs in acceptance order
        smoothed_q.push_back(smooth_pair(d));
        @(negedge clk);
    endtask

    task automatic send_samples(int l, int r);
        cesl_pkg::in_data_t d;
        d.left_sample = l[cesl_pkg::SAMPLE_BITS-1:0];
        d.right_sample = r[cesl_pkg::SAMPLE_BITS-1:0];
        send_pair(d);
    endtask

    // stop offering and let every owed result come out, plus the block's latency
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // sample mix: full range, small, near full scale around the clip threshold,
    // and small steps from the previous sample so both softening branches are hit
    function automatic logic signed [cesl_pkg::SAMPLE_BITS-1:0] pick_sample(
            logic signed [cesl_pkg::SAMPLE_BITS-1:0] prev);
        int v;
        case ($urandom_range(0, 3))
            0: v = int'($urandom);
            1: v = int'($urandom_range(0, 2097151)) - 1048576;
            2:
            begin
                v = int'($urandom_range(7800000, 8388607));
                if ($urandom_range(0, 1) == 1)
                    v = -v - 1;
            end
            default: v = int'(prev) + int'($urandom_range(0, 65535)) - 32768;
        endcase
        return v[cesl_pkg::SAMPLE_BITS-1:0];
    endfunction

    // random register setting with the extremes weighted in
    task automatic pick_settings();
        logic [cesl_pkg::CFG_DATA_W-1:0] val;
        // upper bits of the bypass write are noise that the register must drop
        val = cesl_pkg::CFG_DATA_W'($urandom);
        val[0] = ($urandom_range(0, 5) == 0);
        apply_reg(cesl_pkg::REG_BYPASS, val);
        case ($urandom_range(0, 5))
            0: val = '0;
            1: val = 24'd65536;
            2: val = 24'd16384;
            3: val = 24'hFFFFFF;
            4: val = cesl_pkg::CFG_DATA_W'($urandom);
            default: val = cesl_pkg::CFG_DATA_W'($urandom_range(65536, 262144));
        endcase
        apply_reg(cesl_pkg::REG_INPUT_GAIN, val);
        case ($urandom_range(0, 4))
            0: val = '0;
            1: val = 24'd65536;
            2: val = cesl_pkg::CFG_DATA_W'($urandom);
            default: val = cesl_pkg::CFG_DATA_W'($urandom_range(0, 65536));
        endcase
        apply_reg(cesl_pkg::REG_OUTPUT_GAIN, val);
        if ($urandom_range(0, 3) == 0)
            val = cesl_pkg::CFG_DATA_W'($urandom);
        else
            val = cesl_pkg::CFG_DATA_W'($urandom_range(1, MAX_LEN));
        apply_reg(cesl_pkg::REG_DELAY_LEN, val);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings: unity gains, one sample delay, both clip directions and their release
    task automatic test_default_path();
        send_samples(0, 0);
        send_samples(8388607, -8388608);
        send_samples(8388607, -8388608);
        send_samples(100, -100);
        send_samples(-8388608, 8388607);
        send_samples(-8388608, 8388607);
        send_samples(0, 0);
        send_samples(5000000, -5000000);
        wait_idle();
    endtask

    // bypass hands inputs straight through and must not disturb the lanes
    task automatic test_bypass();
        apply_reg(cesl_pkg::REG_BYPASS, 24'd1);
        send_samples(8388607, -8388608);
        send_samples(-8388608, 8388607);
        send_samples(5592405, -5592406);
        wait_idle();
        apply_reg(cesl_pkg::REG_BYPASS, 24'd0);
    endtask

    // gain limits, output gain above unity through an over-wide write, delay length zero
    task automatic test_gain_limits();
        apply_reg(cesl_pkg::REG_INPUT_GAIN, 24'hFFFFFF);
        apply_reg(cesl_pkg::REG_OUTPUT_GAIN, 24'hFFFFFF);
        apply_reg(cesl_pkg::REG_DELAY_LEN, 24'd0);
        send_samples(1, -1);
        send_samples(-1, 1);
        send_samples(8388607, -8388608);
        wait_idle();
        apply_reg(cesl_pkg::REG_INPUT_GAIN, 24'd0);
        apply_reg(cesl_pkg::REG_OUTPUT_GAIN, 24'd0);
        send_samples(8388607, -8388608);
        send_samples(-8388608, 8388607);
        wait_idle();
    endtask

    // delay above the maximum acts as the maximum, then the length changes mid-stream
    task automatic test_delay_change();
        apply_reg(cesl_pkg::REG_INPUT_GAIN, 24'd65536);
        apply_reg(cesl_pkg::REG_OUTPUT_GAIN, 24'd65536);
        apply_reg(cesl_pkg::REG_DELAY_LEN, 24'd31);
        send_samples(4000000, -4000000);
        send_samples(-3000000, 3000000);
        send_samples(8388607, -8388608);
        send_samples(2000000, -2000000);
        wait_idle();
        apply_reg(cesl_pkg::REG_DELAY_LEN, 24'd3);
        send_samples(1234567, -7654321);
        send_samples(-8388608, 8388607);
        send_samples(0, 0);
        wait_idle();
        apply_reg(cesl_pkg::REG_DELAY_LEN, 24'd16);
    endtask

    // random transactions in segments, each segment under a fresh register setting
    task automatic test_random_traffic(int total, int s_pct, int r_pct);
        int sent;
        int seg;
        int k;
        cesl_pkg::in_data_t d;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < total)
        begin
            pick_settings();
            seg = $urandom_range(25, 55);
            for (k = 0; k < seg; k++)
            begin
                d.left_sample = pick_sample(last_left);
                d.right_sample = pick_sample(last_right);
                last_left = d.left_sample;
                last_right = d.right_sample;
                send_pair(d);
            end
            sent += seg;
            wait_idle();
        end
    endtask

    // receiver holds off long enough for the block to fill and stall its input,
    // then the sender pauses until everything owed has come out
    task automatic test_backpressure();
        int k;
        cesl_pkg::in_data_t d;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_len = 300;
        hold_seq = hold_seq + 1;
        for (k = 0; k < 24; k++)
        begin
            d.left_sample = pick_sample(last_left);
            d.right_sample = pick_sample(last_right);
            last_left = d.left_sample;
            last_right = d.right_sample;
            send_pair(d);
        end
        wait_idle();
        recv_idle_pct = 46;
        for (k = 0; k < 12; k++)
        begin
            d.left_sample = pick_sample(last_left);
            d.right_sample = pick_sample(last_right);
            send_pair(d);
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // receiver stall and result checking
    // ------------------------------------------------------------------

    // stall decided at the falling edge; a requested hold-off is counted down here
    always @(negedge clk)
    begin
        if (hold_seq != hold_seen)
        begin
            hold_seen = hold_seq;
            hold_left = hold_len;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // each accepted result is compared with the oldest owed pair
    always @(posedge clk)
    begin
        cesl_pkg::out_data_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (smoothed_q.size() == 0)
            begin
                $error("unexpected transaction: left_out %0d, right_out %0d",
                       out_data.left_out, out_data.right_out);
                err_count++;
            end
            else
            begin
                want = smoothed_q.pop_front();
                if (out_data.left_out !== want.left_out)
                begin
                    $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
                    err_count++;
                end
                if (out_data.right_out !== want.right_out)
                begin
                    $error("right_out: expected %0d, got %0d",
                           want.right_out, out_data.right_out);
                    err_count++;
                end
            end
        end
    end

    // cycle budget for the whole run
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin
        int ch;
        int k;
        for (ch = 0; ch < 2; ch++)
        begin
            held_q[ch] = '0;
            pos_clip[ch] = 1'b0;
            neg_clip[ch] = 1'b0;
            for (k = 0; k < MAX_LEN; k++)
                delay_q[ch][k] = '0;
        end
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_default_path();
        test_bypass();
        test_gain_limits();
        test_delay_change();
        // receiver stalling more than the sender idles, then the reverse, then full rate
        test_random_traffic(200, 20, 46);
        test_random_traffic(200, 46, 20);
        test_random_traffic(200, 0, 0);
        test_backpressure();

        wait_idle();
        if (err_count == 0 && smoothed_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
